// File: rtl/core/wpms_pkg.sv
// shared types and constants of the windowed peak match select block
package wpms_pkg;

    localparam int CoordWidth = 32;
    localparam int MassWidth  = 12;
    localparam int InstWidth  = 32;
    localparam int TargWidth  = 16;
    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 32;

    typedef enum logic [1:0] {
        MODE_ALL     = 2'd0,
        MODE_CLOSEST = 2'd1,
        MODE_INTENSE = 2'd2
    } mode_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_TARGET_MASS  = 3'd0,
        REG_WINDOW_LOW   = 3'd1,
        REG_WINDOW_HIGH  = 3'd2,
        REG_EXPECTED_POS = 3'd3,
        REG_USE_TIME     = 3'd4,
        REG_SEARCH_MODE  = 3'd5,
        REG_TARGET_ID    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [CoordWidth-1:0] scan_index_pos;
        logic [CoordWidth-1:0] scan_time;
        logic [MassWidth-1:0]  peak_mass;
        logic [InstWidth-1:0]  peak_intensity;
        logic                  last_peak;
    } peak_t;

    typedef struct packed {
        logic                  found;
        logic [CoordWidth-1:0] found_index_pos;
        logic [CoordWidth-1:0] found_time;
        logic [InstWidth-1:0]  found_intensity;
        logic [TargWidth-1:0]  found_target;
        logic                  end_of_search;
    } result_t;

    typedef struct packed {
        logic [MassWidth-1:0]  target_mass;
        logic [CoordWidth-1:0] window_low;
        logic [CoordWidth-1:0] window_high;
        logic [CoordWidth-1:0] expected_position;
        logic                  use_time;
        logic [1:0]            search_mode;
        logic [TargWidth-1:0]  target_id;
    } cfg_t;

    typedef struct packed {
        logic                  match;
        logic [CoordWidth-1:0] distance;
    } match_info_t;

endpackage

// File: rtl/core/windowed_peak_match_select.sv
// top level of the windowed peak match select block
// Peaks enter one beat per cycle into an input register; the match test,
// the distance to the expected position and the best-match compare run
// combinationally from that register into the result register, so the sustained
// rate is one peak per clock; a result beat is registered as its peak leaves the
// input register. In mode all every match gives a result beat at once; in the
// closest and most intense modes one result beat comes with the last peak,
// and the last peak always gives a result even when nothing matched. The
// limit on rate is only the output side: while the result register holds a
// beat that is stalled, a peak that causes a result waits in the input
// register, while peaks that cause none keep flowing. Configuration writes
// are always ready and take effect the next cycle; write them only while
// no peak is in flight. Indexes beyond the register list are ignored.
module windowed_peak_match_select
    import wpms_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    // peak input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  peak_t                   in_data,

    // result output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output result_t                 out_data,

    // configuration write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data
);

    cfg_t        cfg;
    match_info_t info;

    // input register stage
    logic  s1_valid_reg;
    logic  s1_valid_next;
    peak_t s1_data_reg;

    // result register stage
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;

    logic    s1_has_result;
    result_t s1_result;
    logic    out_free;
    logic    s1_go;

    assign cfg_ready = 1'b1;

    wpms_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    wpms_match u_match
    (
        .peak (s1_data_reg),
        .cfg  (cfg),
        .info (info)
    );

    wpms_select u_select
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (s1_go),
        .peak       (s1_data_reg),
        .info       (info),
        .cfg        (cfg),
        .has_result (s1_has_result),
        .result     (s1_result)
    );

    // result register empties or is taken this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // a peak leaves the input register when it has no result or room waits
    assign s1_go    = s1_valid_reg && (!s1_has_result || out_free);
    assign in_stall = s1_valid_reg && !s1_go;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        if (!in_stall)
            s1_valid_next = in_valid;
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = s1_go && s1_has_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_data_reg <= in_data;
        if (s1_go && s1_has_result)
            out_data_reg <= s1_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/core/wpms_cfg.sv
// configuration register file
module wpms_cfg
    import wpms_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [CfgIdxWidth-1:0]  wr_index,
    input  logic [CfgDataWidth-1:0] wr_data,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_TARGET_MASS:  cfg_next.target_mass       = wr_data[MassWidth-1:0];
                REG_WINDOW_LOW:   cfg_next.window_low        = wr_data[CoordWidth-1:0];
                REG_WINDOW_HIGH:  cfg_next.window_high       = wr_data[CoordWidth-1:0];
                REG_EXPECTED_POS: cfg_next.expected_position = wr_data[CoordWidth-1:0];
                REG_USE_TIME:     cfg_next.use_time          = wr_data[0];
                REG_SEARCH_MODE:  cfg_next.search_mode       = wr_data[1:0];
                REG_TARGET_ID:    cfg_next.target_id         = wr_data[TargWidth-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/wpms_match.sv
// mass and window match test and distance to the expected position
module wpms_match
    import wpms_pkg::*;
(
    input  peak_t       peak,
    input  cfg_t        cfg,
    output match_info_t info
);

    logic [CoordWidth-1:0] coord;
    logic [CoordWidth-1:0] diff_up;
    logic [CoordWidth-1:0] diff_down;

    always_comb
    begin
        coord     = cfg.use_time ? peak.scan_time : peak.scan_index_pos;
        diff_up   = cfg.expected_position - coord;
        diff_down = coord - cfg.expected_position;
        info.match = (peak.peak_mass == cfg.target_mass)
                  && (cfg.window_low < coord)
                  && (coord < cfg.window_high);
        info.distance = (cfg.expected_position >= coord) ? diff_up : diff_down;
    end

endmodule

// File: rtl/core/wpms_select.sv
// kept best match and result forming
module wpms_select
    import wpms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  peak_t       peak,
    input  match_info_t info,
    input  cfg_t        cfg,
    output logic        has_result,
    output result_t     result
);

    logic                  have_best_reg,  have_best_next;
    logic [CoordWidth-1:0] best_index_reg, best_index_next;
    logic [CoordWidth-1:0] best_time_reg,  best_time_next;
    logic [InstWidth-1:0]  best_inten_reg, best_inten_next;
    logic [CoordWidth-1:0] best_dist_reg,  best_dist_next;

    logic best_mode;
    logic better;
    logic take;
    logic cand_have;

    always_comb
    begin
        best_mode = (cfg.search_mode == MODE_CLOSEST) || (cfg.search_mode == MODE_INTENSE);
        if (!have_best_reg)
            better = 1'b1;
        else if (cfg.search_mode == MODE_CLOSEST)
            better = info.distance < best_dist_reg;
        else
            better = peak.peak_intensity > best_inten_reg;
        take      = best_mode && info.match && better;
        cand_have = have_best_reg || take;

        result.found_target  = cfg.target_id;
        if (best_mode)
        begin
            has_result             = peak.last_peak;
            result.found           = cand_have;
            result.end_of_search   = 1'b1;
            result.found_index_pos = !cand_have ? '0
                                   : (take ? peak.scan_index_pos : best_index_reg);
            result.found_time      = !cand_have ? '0
                                   : (take ? peak.scan_time : best_time_reg);
            result.found_intensity = !cand_have ? '0
                                   : (take ? peak.peak_intensity : best_inten_reg);
        end
        else
        begin
            has_result             = info.match || peak.last_peak;
            result.found           = info.match;
            result.end_of_search   = peak.last_peak;
            result.found_index_pos = info.match ? peak.scan_index_pos : '0;
            result.found_time      = info.match ? peak.scan_time : '0;
            result.found_intensity = info.match ? peak.peak_intensity : '0;
        end

        have_best_next  = have_best_reg;
        best_index_next = best_index_reg;
        best_time_next  = best_time_reg;
        best_inten_next = best_inten_reg;
        best_dist_next  = best_dist_reg;
        if (advance)
        begin
            priority if (peak.last_peak)
            begin
                have_best_next  = 1'b0;
                best_index_next = '0;
                best_time_next  = '0;
                best_inten_next = '0;
                best_dist_next  = '0;
            end
            else if (take)
            begin
                have_best_next  = 1'b1;
                best_index_next = peak.scan_index_pos;
                best_time_next  = peak.scan_time;
                best_inten_next = peak.peak_intensity;
                best_dist_next  = info.distance;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg  <= 1'b0;
            best_index_reg <= '0;
            best_time_reg  <= '0;
            best_inten_reg <= '0;
            best_dist_reg  <= '0;
        end
        else
        begin
            have_best_reg  <= have_best_next;
            best_index_reg <= best_index_next;
            best_time_reg  <= best_time_next;
            best_inten_reg <= best_inten_next;
            best_dist_reg  <= best_dist_next;
        end
    end

endmodule

// File: dv/windowed_peak_match_select_tb.sv
// self-checking testbench for the windowed peak match select block
`timescale 1ns / 1ps

module windowed_peak_match_select_tb
    import wpms_pkg::*;
;

    localparam int CycleLimit    = 1_000_000;
    localparam int HoldCycles    = 400;
    localparam int RandomPhases  = 12;
    localparam int PhaseItems    = 150;
    localparam int SettleCycles  = 4;
    localparam int ErrorPrintCap = 50;

    // register index past the end of the list, the block must ignore it
    localparam logic [CfgIdxWidth-1:0] RegUnused  = 3'd7;
    // spare mode code, the block treats it as mode all
    localparam logic [1:0]             ModeUnused = 2'd3;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    peak_t                   in_data   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    result_t                 out_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CfgIdxWidth-1:0]  cfg_index = '0;
    logic [CfgDataWidth-1:0] cfg_data  = '0;

    // peaks waiting to be driven, results still owed by the block
    peak_t   peaks_to_send[$];
    result_t results_due[$];

    // our copy of the register file and of the kept best match
    cfg_t                  search_cfg = '0;
    logic                  kept_ok        = 1'b0;
    logic [CoordWidth-1:0] kept_index     = '0;
    logic [CoordWidth-1:0] kept_time      = '0;
    logic [InstWidth-1:0]  kept_intensity = '0;
    logic [CoordWidth-1:0] kept_distance  = '0;

    int errors      = 0;
    int cycle_count = 0;
    int send_gap    = 0;
    int stall_run   = 0;
    int hold_left   = 0;
    bit squeeze_req  = 1'b0;
    bit squeeze_done = 1'b0;
    bit quiet        = 1'b0;

    windowed_peak_match_select DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // idle length: mostly short, now and then long
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void clear_kept();
        kept_ok        = 1'b0;
        kept_index     = '0;
        kept_time      = '0;
        kept_intensity = '0;
        kept_distance  = '0;
    endfunction

    // window test, distance and best-match update for one accepted peak;
    // queues the result beat the peak causes, if any
    function automatic void track_peak(peak_t p);
        logic [CoordWidth-1:0] coord;
        logic [CoordWidth-1:0] distance;
        logic                  hit;
        logic                  better;
        result_t               r;
        coord = search_cfg.use_time ? p.scan_time : p.scan_index_pos;
        hit = (p.peak_mass == search_cfg.target_mass) &&
              (search_cfg.window_low < coord) && (coord < search_cfg.window_high);
        distance = (search_cfg.expected_position >= coord) ?
                   search_cfg.expected_position - coord :
                   coord - search_cfg.expected_position;
        r = '0;
        r.found_target  = search_cfg.target_id;
        r.end_of_search = p.last_peak;
        if (search_cfg.search_mode == MODE_CLOSEST || search_cfg.search_mode == MODE_INTENSE)
        begin
            if (hit)
            begin
                // ties keep the earlier peak, so strict compares only
                if (!kept_ok)
                    better = 1'b1;
                else if (search_cfg.search_mode == MODE_CLOSEST)
                    better = distance < kept_distance;
                else
                    better = p.peak_intensity > kept_intensity;
                if (better)
                begin
                    kept_ok        = 1'b1;
                    kept_index     = p.scan_index_pos;
                    kept_time      = p.scan_time;
                    kept_intensity = p.peak_intensity;
                    kept_distance  = distance;
                end
            end
            if (p.last_peak)
            begin
                r.found = kept_ok;
                if (kept_ok)
                begin
                    r.found_index_pos = kept_index;
                    r.found_time      = kept_time;
                    r.found_intensity = kept_intensity;
                end
                results_due.push_back(r);
                clear_kept();
            end
        end
        else
        begin
            // mode all and the spare mode: every match goes out at once
            if (p.last_peak)
                clear_kept();
            if (hit)
            begin
                r.found           = 1'b1;
                r.found_index_pos = p.scan_index_pos;
                r.found_time      = p.scan_time;
                r.found_intensity = p.peak_intensity;
                results_due.push_back(r);
            end
            else if (p.last_peak)
            begin
                results_due.push_back(r);
            end
        end
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= ErrorPrintCap)
                $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endfunction

    function automatic cfg_t make_cfg(logic [MassWidth-1:0] mass, logic [CoordWidth-1:0] lo,
                                      logic [CoordWidth-1:0] hi, logic [CoordWidth-1:0] pos,
                                      logic ut, logic [1:0] mode, logic [TargWidth-1:0] id);
        cfg_t c;
        c.target_mass       = mass;
        c.window_low        = lo;
        c.window_high       = hi;
        c.expected_position = pos;
        c.use_time          = ut;
        c.search_mode       = mode;
        c.target_id         = id;
        return c;
    endfunction

    // register settings for a random phase, extremes weighted in
    function automatic cfg_t random_cfg();
        logic [CoordWidth-1:0] a;
        logic [CoordWidth-1:0] b;
        logic [CoordWidth-1:0] lo;
        logic [CoordWidth-1:0] hi;
        logic [CoordWidth-1:0] pos;
        logic [MassWidth-1:0]  mass;
        logic [TargWidth-1:0]  id;
        logic [1:0]            mode;
        int                    pick;
        a = $urandom;
        b = $urandom;
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin lo = '0; hi = '1; end
            1: begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end  // empty or reversed
            2: begin lo = a; hi = a + $urandom_range(1, 3); end       // very narrow
            3, 4, 5: begin lo = a; hi = a + $urandom_range(2, 1 << 20); end
            default: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
        endcase
        pick = $urandom_range(0, 9);
        if (pick == 0)
            pos = '0;
        else if (pick == 1)
            pos = '1;
        else if (pick < 5 && hi > lo)
            pos = lo + (hi - lo) / 2;
        else
            pos = $urandom;
        pick = $urandom_range(0, 9);
        mass = (pick < 2) ? '0 : (pick < 4) ? '1 : MassWidth'($urandom);
        pick = $urandom_range(0, 9);
        id = (pick == 0) ? '0 : (pick == 1) ? '1 : TargWidth'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            mode = MODE_ALL;
        else if (pick < 65)
            mode = MODE_CLOSEST;
        else if (pick < 95)
            mode = MODE_INTENSE;
        else
            mode = ModeUnused;
        return make_cfg(mass, lo, hi, pos, 1'($urandom_range(0, 1)), mode, id);
    endfunction

    function automatic void add_peak(logic [CoordWidth-1:0] ri, logic [CoordWidth-1:0] rt,
                                     logic [MassWidth-1:0] mass, logic [InstWidth-1:0] inten,
                                     logic last);
        peak_t p;
        p.scan_index_pos = ri;
        p.scan_time      = rt;
        p.peak_mass      = mass;
        p.peak_intensity = inten;
        p.last_peak      = last;
        peaks_to_send.push_back(p);
    endfunction

    // one register write beat; called at a rising edge, leaves valid high
    // so back-to-back writes do not drop it in between
    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_TARGET_MASS:  search_cfg.target_mass       = data[MassWidth-1:0];
            REG_WINDOW_LOW:   search_cfg.window_low        = data;
            REG_WINDOW_HIGH:  search_cfg.window_high       = data;
            REG_EXPECTED_POS: search_cfg.expected_position = data;
            REG_USE_TIME:     search_cfg.use_time          = data[0];
            REG_SEARCH_MODE:  search_cfg.search_mode       = data[1:0];
            REG_TARGET_ID:    search_cfg.target_id         = data[TargWidth-1:0];
            default: ;
        endcase
    endtask

    // narrow registers get junk in their unused upper bits
    task automatic apply_cfg(cfg_t c);
        logic [CfgDataWidth-1:0] junk;
        junk = $urandom;
        junk[MassWidth-1:0] = c.target_mass;
        write_reg(REG_TARGET_MASS, junk);
        write_reg(REG_WINDOW_LOW, c.window_low);
        write_reg(REG_WINDOW_HIGH, c.window_high);
        write_reg(REG_EXPECTED_POS, c.expected_position);
        junk = $urandom;
        junk[0] = c.use_time;
        write_reg(REG_USE_TIME, junk);
        junk = $urandom;
        junk[1:0] = c.search_mode;
        write_reg(REG_SEARCH_MODE, junk);
        junk = $urandom;
        junk[TargWidth-1:0] = c.target_id;
        write_reg(REG_TARGET_ID, junk);
        write_reg(RegUnused, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // sampled on the falling edge so the driver's pops have settled;
    // peaks that cause no result may still be in the pipe, hence the settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (peaks_to_send.size() != 0 || in_valid || results_due.size() != 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // stimulus: directed phases, then random phases with fresh settings
    initial
    begin
        cfg_t                  c;
        logic [CoordWidth-1:0] coord;
        logic [MassWidth-1:0]  mass;
        logic [InstWidth-1:0]  inten;
        int                    phase;
        int                    k;
        int                    pick;
        int                    set_left;
        set_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // mode all, full window, zero mass: boundaries are exclusive
        apply_cfg(make_cfg('0, '0, '1, '0, 1'b0, MODE_ALL, '1));
        add_peak('0, 32'd5, '0, 32'd1, 1'b0);             // on the low bound
        add_peak('1, 32'd5, '0, 32'd2, 1'b0);             // on the high bound
        add_peak(32'd1, '0, '0, '1, 1'b0);                // just inside
        add_peak(32'hFFFF_FFFE, '1, '0, '0, 1'b0);        // just inside at the top
        add_peak(32'd100, 32'd100, '1, 32'd3, 1'b1);      // last, wrong mass
        add_peak(32'd200, 32'd7, '0, 32'd9, 1'b1);        // last and a match
        wait_idle();

        // closest on time: equal distance keeps the first, better one wins
        apply_cfg(make_cfg('1, 32'd100, 32'd1000, 32'd500, 1'b1, MODE_CLOSEST, '0));
        add_peak(32'd600, 32'd400, '1, 32'd10, 1'b0);
        add_peak(32'd5, 32'd600, '1, 32'd20, 1'b0);
        add_peak(32'd900, 32'd450, '1, 32'd30, 1'b0);
        add_peak('0, 32'd1000, '1, 32'd40, 1'b0);
        add_peak('0, 32'd499, 12'hFFE, 32'd50, 1'b1);
        add_peak('0, 32'd50, '1, 32'd1, 1'b1);            // search with no match
        wait_idle();

        // most intense: equal intensity keeps the first
        apply_cfg(make_cfg('1, 32'd100, 32'd1000, 32'd500, 1'b1, MODE_INTENSE, 16'h5A5A));
        add_peak(32'd1, 32'd200, '1, 32'd7, 1'b0);
        add_peak(32'd2, 32'd300, '1, 32'd7, 1'b0);
        add_peak(32'd3, 32'd999, '1, '1, 1'b0);
        add_peak(32'd4, 32'd101, '1, '0, 1'b1);
        wait_idle();

        // spare mode with a reversed window: nothing can match
        apply_cfg(make_cfg('1, 32'd600, 32'd500, 32'd500, 1'b1, ModeUnused, 16'h1234));
        add_peak('0, 32'd550, '1, 32'd1, 1'b0);
        add_peak('0, 32'd550, '1, 32'd1, 1'b1);
        wait_idle();

        // mode switched mid-search: kept best carries over
        apply_cfg(make_cfg(12'h123, '0, '1, '0, 1'b0, MODE_CLOSEST, 16'h00FF));
        add_peak(32'd50, '0, 12'h123, 32'd100, 1'b0);
        add_peak(32'd40, '0, 12'h123, 32'd5, 1'b0);
        wait_idle();
        apply_cfg(make_cfg(12'h123, '0, '1, '0, 1'b0, MODE_INTENSE, 16'h00FF));
        add_peak(32'd60, '0, 12'h123, 32'd50, 1'b1);
        wait_idle();

        for (phase = 0; phase < RandomPhases; phase++)
        begin
            c = random_cfg();
            if (phase == 0)
            begin
                // a wide-open window lets many peaks match, and the receiver holds off
                c.search_mode = MODE_ALL;
                c.window_low  = '0;
                c.window_high = '1;
                squeeze_req   = 1'b1;
            end
            quiet = (phase == 0) || (phase % 4 == 1);
            apply_cfg(c);
            for (k = 0; k < PhaseItems; k++)
            begin
                // data sets may run across a phase boundary
                if (set_left == 0)
                    set_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                          : $urandom_range(1, 12);
                pick = $urandom_range(0, 99);
                if (pick < 55 && c.window_high > c.window_low &&
                    c.window_high - c.window_low >= 2)
                    coord = $urandom_range(c.window_high - 1, c.window_low + 1);
                else if (pick < 65)
                    coord = c.window_low;
                else if (pick < 72)
                    coord = c.window_high;
                else if (pick < 82)
                    coord = c.expected_position + $urandom_range(0, 8) - 4;  // distance ties
                else
                    coord = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    mass = c.target_mass;
                else if (pick < 75)
                    mass = c.target_mass ^ (12'd1 << $urandom_range(0, MassWidth - 1));
                else
                    mass = MassWidth'($urandom_range(0, (1 << MassWidth) - 1));
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    inten = $urandom_range(0, 3);                // intensity ties
                else if (pick < 20)
                    inten = '0;
                else if (pick < 25)
                    inten = '1;
                else
                    inten = $urandom;
                if (c.use_time)
                    add_peak($urandom, coord, mass, inten, set_left == 1);
                else
                    add_peak(coord, $urandom, mass, inten, set_left == 1);
                set_left--;
            end
            wait_idle();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // input driver: holds the beat until taken, random gaps between beats
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                track_peak(in_data);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (peaks_to_send.size() != 0)
                begin
                    in_data  <= peaks_to_send.pop_front();
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 3) == 0)
                        send_gap = gap_len();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall: one long hold-off, otherwise random runs of stall
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (squeeze_req && !squeeze_done)
        begin
            squeeze_done = 1'b1;
            hold_left    = HoldCycles;
            out_stall <= 1'b1;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
        end
        else if (quiet)
        begin
            out_stall <= 1'b0;
            stall_run = $urandom_range(8, 40);
        end
        else
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            stall_run = gap_len();
        end
    end

    // result monitor: every taken beat against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                errors++;
                if (errors <= ErrorPrintCap)
                    $display("%0t: result beat with none expected, expected nothing, got %h",
                             $time, out_data);
            end
            else
            begin
                want = results_due.pop_front();
                check_field("found", want.found, out_data.found);
                check_field("found_index_pos", want.found_index_pos, out_data.found_index_pos);
                check_field("found_time", want.found_time, out_data.found_time);
                check_field("found_intensity", want.found_intensity, out_data.found_intensity);
                check_field("found_target", want.found_target, out_data.found_target);
                check_field("end_of_search", want.end_of_search, out_data.end_of_search);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
